>>> design/assert_macros.svh
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, muted while reset is high
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked check that also holds during reset
`define ASSERT_CLK(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/tvpm_pkg.sv
`default_nettype none

package tvpm_pkg;

   localparam int DIST_BITS  = 16;
   localparam int COUNT_BITS = 24;
   localparam int SUM_BITS   = 56;
   localparam int MEAN_BITS  = 32;
   localparam int T_BITS     = DIST_BITS + 2;
   localparam int SQ_BITS    = 2 * DIST_BITS;
   localparam int ALU_BITS   = SUM_BITS + 2;
   localparam int ITER_BITS  = $clog2(SUM_BITS);

   localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [MEAN_BITS-1:0]  MEAN_MAX  = {MEAN_BITS{1'b1}};
   localparam logic [ITER_BITS-1:0]  ITER_LAST = ITER_BITS'(SUM_BITS - 1);

   typedef struct packed {
      logic [DIST_BITS-1:0] dist_ab;
      logic [DIST_BITS-1:0] dist_bc;
      logic [DIST_BITS-1:0] dist_ca;
      logic                 last_triple;
   } req_type;

   typedef struct packed {
      logic [MEAN_BITS-1:0]  mean_penalty;
      logic [COUNT_BITS-1:0] triple_total;
      logic                  count_overflow;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SUM1,
      S_SUM2,
      S_MAXAB,
      S_MAXC,
      S_EXC,
      S_SQR,
      S_ACC,
      S_DIV,
      S_DONE
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef struct packed {
      state_type state;
      logic      load;
      logic      clear;
   } ctrl_type;

   typedef struct packed {
      logic last;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

>>> design/triangle_violation_penalty_mean.sv
// channel   ports                           direction  payload
// req       req_valid req_ready req_data    in         req_type, one distance triple
// rsp       rsp_valid rsp_ready rsp_data    out        rsp_type, mean of one set
//
// a triple that is not last runs from accept to next accept
// as the sequencer steps the one shared adder through its steps
// a last triple adds 56 division steps on that adder plus an unload state
// reset is synchronous and active high; it clears totals and the sequencer
// a result waiting in the output register does not stall accumulation;
// only the next result waits for rsp_ready to free that register
`default_nettype none

module triangle_violation_penalty_mean
   import tvpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

`include "assert_macros.svh"

   ctrl_type   ctrl;
   status_type status;
   logic       last;
   rsp_type    result;

   // output register, parts the result side from the sequencer
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   // sequencer: walks each triple through sum, max, excess, square, accumulate, and divides after the last
   tvpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .req_ready (req_ready),
      .ctrl      (ctrl)
   );

   // datapath with the shared adder, multiplier and running totals
   tvpm_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .req_data (req_data),
      .last     (last),
      .result   (result)
   );

   always_comb begin
      status.last     = last;
      status.out_free = !rsp_valid_ff || rsp_ready;
   end

   // load on clear, drop once the transaction is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.clear) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a set always counts at least its last triple
   `ASSERT_CLK_RST(a_count_nz, clock, reset, ctrl.clear |-> (|result.triple_total), "empty set")
   // never overwrite a result that is still waiting
   `ASSERT_CLK_RST(a_no_overwrite, clock, reset, ctrl.clear |-> status.out_free, "overwrite")
   // the block is busy right after it takes a triple
   `ASSERT_CLK_RST(a_busy_after_load, clock, reset, ctrl.load |=> !req_ready, "ready after load")

endmodule

`default_nettype wire

>>> design/tvpm_alu.sv
`default_nettype none

module tvpm_alu
   import tvpm_pkg::*;
(
   input  wire alu_op_type          op,
   input  wire logic [ALU_BITS-1:0] x,
   input  wire logic [ALU_BITS-1:0] y,
   output logic      [ALU_BITS-1:0] res,
   output logic                     neg
);

   always_comb begin
      unique case (op)
         ALU_ADD: res = x + y;
         ALU_SUB: res = x - y;
         default: res = x + y;
      endcase
      // operands stay below 2^(ALU_BITS-1), so the top bit is the sign
      neg = res[ALU_BITS-1];
   end

endmodule

`default_nettype wire

>>> design/tvpm_ctrl.sv
`default_nettype none

module tvpm_ctrl
   import tvpm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire status_type status,
   output logic            req_ready,
   output ctrl_type        ctrl
);

   state_type             state_ff, state_in;
   logic [ITER_BITS-1:0]  iter_ff, iter_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         iter_ff  <= '0;
      end else begin
         state_ff <= state_in;
         iter_ff  <= iter_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (req_valid) state_in = S_SUM1;
         S_SUM1:  state_in = S_SUM2;
         S_SUM2:  state_in = S_MAXAB;
         S_MAXAB: state_in = S_MAXC;
         S_MAXC:  state_in = S_EXC;
         S_EXC:   state_in = S_SQR;
         S_SQR:   state_in = S_ACC;
         S_ACC:   state_in = status.last ? S_DIV : S_IDLE;
         S_DIV:   if (iter_ff == ITER_LAST) state_in = S_DONE;
         S_DONE:  if (status.out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // division step counter
   always_comb begin
      if (state_ff == S_DIV) begin
         iter_in = iter_ff + 1'b1;
      end else begin
         iter_in = '0;
      end
   end

   // outputs
   always_comb begin
      req_ready  = (state_ff == S_IDLE);
      ctrl.state = state_ff;
      ctrl.load  = (state_ff == S_IDLE) && req_valid;
      ctrl.clear = (state_ff == S_DONE) && status.out_free;
   end

endmodule

`default_nettype wire

>>> design/tvpm_dp.sv
`default_nettype none

module tvpm_dp
   import tvpm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire ctrl_type ctrl,
   input  wire req_type  req_data,
   output logic          last,
   output rsp_type       result
);

   logic [DIST_BITS-1:0]  a_ff, b_ff, c_ff, big_ff, d_ff;
   logic [DIST_BITS-1:0]  a_in, b_in, c_in, big_in, d_in;
   logic                  last_ff, last_in;
   logic [T_BITS-1:0]     t_ff, t_in;
   logic [SQ_BITS-1:0]    sq_ff, sq_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in, rem_ff, rem_in;
   logic                  ovf_ff, ovf_in;
   logic [COUNT_BITS:0]   trial;

   alu_op_type            alu_op;
   logic [ALU_BITS-1:0]   alu_x, alu_y, alu_res;
   logic                  alu_neg;

   tvpm_alu u_alu (
      .op  (alu_op),
      .x   (alu_x),
      .y   (alu_y),
      .res (alu_res),
      .neg (alu_neg)
   );

   assign trial = {rem_ff, sum_ff[SUM_BITS-1]};

   // operand selection for the shared adder
   always_comb begin
      alu_op = ALU_ADD;
      alu_x  = '0;
      alu_y  = '0;
      unique case (ctrl.state)
         S_SUM1: begin
            alu_x = ALU_BITS'(a_ff);
            alu_y = ALU_BITS'(b_ff);
         end
         S_SUM2: begin
            alu_x = ALU_BITS'(t_ff);
            alu_y = ALU_BITS'(c_ff);
         end
         S_MAXAB: begin
            alu_op = ALU_SUB;
            alu_x  = ALU_BITS'(a_ff);
            alu_y  = ALU_BITS'(b_ff);
         end
         S_MAXC: begin
            alu_op = ALU_SUB;
            alu_x  = ALU_BITS'(big_ff);
            alu_y  = ALU_BITS'(c_ff);
         end
         S_EXC: begin
            alu_op = ALU_SUB;
            alu_x  = ALU_BITS'({big_ff, 1'b0});
            alu_y  = ALU_BITS'(t_ff);
         end
         S_ACC: begin
            alu_x = ALU_BITS'(sum_ff);
            alu_y = ALU_BITS'(sq_ff);
         end
         S_DIV: begin
            alu_op = ALU_SUB;
            alu_x  = ALU_BITS'(trial);
            alu_y  = ALU_BITS'(cnt_ff);
         end
         default: begin
            alu_op = ALU_ADD;
         end
      endcase
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      c_in    = c_ff;
      last_in = last_ff;
      t_in    = t_ff;
      big_in  = big_ff;
      d_in    = d_ff;
      sq_in   = sq_ff;
      sum_in  = sum_ff;
      cnt_in  = cnt_ff;
      ovf_in  = ovf_ff;
      rem_in  = rem_ff;
      if (ctrl.load) begin
         a_in    = req_data.dist_ab;
         b_in    = req_data.dist_bc;
         c_in    = req_data.dist_ca;
         last_in = req_data.last_triple;
      end
      unique case (ctrl.state) inside
         S_SUM1, S_SUM2: t_in = alu_res[T_BITS-1:0];
         S_MAXAB: big_in = alu_neg ? b_ff : a_ff;
         S_MAXC: begin
            if (alu_neg) big_in = c_ff;
         end
         S_EXC: d_in = alu_neg ? '0 : alu_res[DIST_BITS-1:0];
         S_SQR: sq_in = SQ_BITS'(d_ff) * SQ_BITS'(d_ff);
         S_ACC: begin
            sum_in = alu_res[SUM_BITS] ? SUM_MAX : alu_res[SUM_BITS-1:0];
            if (cnt_ff == COUNT_MAX) begin
               ovf_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
            rem_in = '0;
         end
         S_DIV: begin
            // restoring division, quotient bits shift in from the right
            rem_in = alu_neg ? trial[COUNT_BITS-1:0] : alu_res[COUNT_BITS-1:0];
            sum_in = {sum_ff[SUM_BITS-2:0], ~alu_neg};
         end
         default: begin
            t_in = t_ff;
         end
      endcase
      if (ctrl.clear) begin
         sum_in = '0;
         cnt_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      last_ff <= last_in;
      t_ff    <= t_in;
      big_ff  <= big_in;
      d_ff    <= d_in;
      sq_ff   <= sq_in;
      rem_ff  <= rem_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         cnt_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         sum_ff <= sum_in;
         cnt_ff <= cnt_in;
         ovf_ff <= ovf_in;
      end
   end

   always_comb begin
      last = last_ff;
      if (|sum_ff[SUM_BITS-1:MEAN_BITS]) begin
         result.mean_penalty = MEAN_MAX;
      end else begin
         result.mean_penalty = sum_ff[MEAN_BITS-1:0];
      end
      result.triple_total   = cnt_ff;
      result.count_overflow = ovf_ff;
   end

endmodule

`default_nettype wire
